FILE: sv/sactc_pkg.sv
// ----------------------------------------------------------------------------
// sactc_pkg
// Shared codes and constants of the set-associative cache tag controller:
// configuration register indexes, replacement modes, LFSR constants and field widths.
// ----------------------------------------------------------------------------
package sactc_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED      = 2'd1;

    // replacement modes, the unused code falls back to lru
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_LRU    = 2'd0;
    localparam t_mode MODE_FIFO   = 2'd1;
    localparam t_mode MODE_RANDOM = 2'd2;

    // galois lfsr
    localparam int          LFSR_W     = 16;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'hACE1;

    // field widths of one word
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 32;
    localparam int WAY_W   = 2;

endpackage

FILE: sv/sactc_ram.sv
// ----------------------------------------------------------------------------
// sactc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (read-before-write on an address collision).
// ----------------------------------------------------------------------------
module sactc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/set_assoc_cache_tag_controller_unit.sv
// An accepted word is held in the input stage register, then the result register.
// Throughput: one word per cycle unless the result side stalls, set by the tag RAM
// read and write-back; a same-set word right behind is forwarded, not stalled.
// Reset: valid bits, hit and miss counters, mode and lfsr are cleared or loaded
// at once; the tag, rank and dirty RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_unit
// Tag directory of a set-associative write-back cache with lru, fifo or
// random replacement, dirty victim reporting and saturating hit/miss counts.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller_unit #(
    parameter int LINE_BYTES = 16,
    parameter int SETS       = 64,
    parameter int WAYS       = 4,
    parameter int ADDR_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sactc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [sactc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // access channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_func,
    input  logic [sactc_pkg::ADDR_W-1:0]       i_address,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hit,
    output logic [sactc_pkg::WAY_W-1:0]        o_way,
    output logic                               o_writeback,
    output logic [sactc_pkg::ADDR_W-1:0]       o_victim_address,
    output logic [sactc_pkg::ADDR_W-1:0]       o_fill_address,
    output logic [sactc_pkg::COUNT_W-1:0]      o_hit_total,
    output logic [sactc_pkg::COUNT_W-1:0]      o_miss_total
);

    localparam int OB    = $clog2(LINE_BYTES);
    localparam int IB    = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int IW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AW    = (ADDR_BITS < sactc_pkg::ADDR_W) ? ADDR_BITS : sactc_pkg::ADDR_W;
    localparam int TAG_W = (AW - OB - IB > 0) ? (AW - OB - IB) : 1;
    localparam int ROW_W = WAYS * (TAG_W + 2 * WW + 1);
    localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [31:0] LMASK = 32'(LINE_BYTES - 1);
    // residues of nibble weights, used to reduce the lfsr value by the way count
    localparam int M1 = 16 % WAYS;
    localparam int M2 = 256 % WAYS;
    localparam int M3 = 4096 % WAYS;

    // lfsr value modulo the way count: fold nibbles, then restoring reduction
    function automatic logic [WW-1:0] f_lfsr_way(input logic [15:0] x);
        logic [10:0] s;
        s = 11'(x[3:0]) + 11'(x[7:4]) * 11'(M1) + 11'(x[11:8]) * 11'(M2)
          + 11'(x[15:12]) * 11'(M3);
        for (int k = 6; k >= 0; k--) begin
            if (s >= 11'(WAYS << k)) begin
                s = s - 11'(WAYS << k);
            end
        end
        return WW'(s);
    endfunction

    // handshake
    logic in_accept;
    logic s1_adv;

    // registers
    logic                     r_s1_v;
    logic                     r_s1_func;
    logic [31:0]              r_s1_addr;
    logic                     r_fwd_hit;
    logic [ROW_W-1:0]         r_fwd_row;
    logic [SETS-1:0][WAYS-1:0] r_valid;
    sactc_pkg::t_mode         r_mode;
    logic [15:0]              r_lfsr;
    logic [31:0]              r_hits;
    logic [31:0]              r_misses;
    logic                     r_out_v;
    logic                     r_out_hit;
    logic [sactc_pkg::WAY_W-1:0] r_out_way;
    logic                     r_out_wb;
    logic [31:0]              r_out_victim;
    logic [31:0]              r_out_fill;

    // stage signals
    logic [IW-1:0]            in_set;
    logic [IW-1:0]            s1_set;
    logic [31:0]              addr_m;
    logic [TAG_W-1:0]         s1_tag;
    logic [ROW_W-1:0]         ram_rdata;
    logic [ROW_W-1:0]         row;
    logic [WAYS-1:0][TAG_W-1:0] row_tag;
    logic [WAYS-1:0][WW-1:0]  row_rr;
    logic [WAYS-1:0][WW-1:0]  row_fr;
    logic [WAYS-1:0][TAG_W-1:0] n_tag;
    logic [WAYS-1:0][WW-1:0]  n_rr;
    logic [WAYS-1:0][WW-1:0]  n_fr;
    logic [ROW_W-1:0]         wr_row;
    logic [WAYS-1:0]          vbits;
    logic [WAYS-1:0]          dbits;
    logic [WAYS-1:0]          n_vbits;
    logic [WAYS-1:0]          n_dbits;
    logic [WAYS-1:0]          hit_vec;
    logic [WAYS-1:0]          old_rr_vec;
    logic [WAYS-1:0]          old_fr_vec;
    logic                     hit;
    logic                     any_free;
    logic [WW-1:0]            hit_way;
    logic [WW-1:0]            free_way;
    logic [WW-1:0]            old_rr_way;
    logic [WW-1:0]            old_fr_way;
    logic [WW-1:0]            way;
    logic [15:0]              lfsr_step;
    logic                     use_rnd;
    logic                     was_valid;
    logic                     wb;
    logic [31:0]              victim;
    logic [31:0]              fill;
    logic [31:0]              n_hits;
    logic [31:0]              n_misses;

    // handshake control
    assign s1_adv      = r_s1_v && (!r_out_v || i_out_ready);
    assign o_in_ready  = !r_s1_v || s1_adv;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign in_set = IW'((i_address & AMASK) >> OB) & IW'(SETS - 1);

    // tag, rank and dirty rows, one per set
    sactc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (s1_set),
        .i_wdata (wr_row),
        .i_re    (in_accept),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // address split and row select with forwarding
    always_comb begin
        addr_m = r_s1_addr & AMASK;
        s1_set = IW'(addr_m >> OB) & IW'(SETS - 1);
        s1_tag = TAG_W'(addr_m >> (OB + IB));
        row    = r_fwd_hit ? r_fwd_row : ram_rdata;
    end

    assign {row_tag, row_rr, row_fr, dbits} = row;
    assign vbits = r_valid[s1_set];

    // tag match, first free way and oldest ways
    always_comb begin
        for (int v = 0; v < WAYS; v++) begin
            hit_vec[v]    = vbits[v] && (row_tag[v] == s1_tag);
            old_rr_vec[v] = 1'b1;
            old_fr_vec[v] = 1'b1;
            for (int u = 0; u < WAYS; u++) begin
                if (u < v) begin
                    old_rr_vec[v] = old_rr_vec[v] && (row_rr[v] > row_rr[u]);
                    old_fr_vec[v] = old_fr_vec[v] && (row_fr[v] > row_fr[u]);
                end else if (u > v) begin
                    old_rr_vec[v] = old_rr_vec[v] && (row_rr[v] >= row_rr[u]);
                    old_fr_vec[v] = old_fr_vec[v] && (row_fr[v] >= row_fr[u]);
                end
            end
        end
        hit_way    = '0;
        free_way   = '0;
        old_rr_way = '0;
        old_fr_way = '0;
        for (int v = WAYS - 1; v >= 0; v--) begin
            if (hit_vec[v])    hit_way    = WW'(v);
            if (!vbits[v])     free_way   = WW'(v);
            if (old_rr_vec[v]) old_rr_way = WW'(v);
            if (old_fr_vec[v]) old_fr_way = WW'(v);
        end
        hit      = |hit_vec;
        any_free = !(&vbits);
    end

    // way choice
    always_comb begin
        lfsr_step = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? sactc_pkg::LFSR_TAPS : 16'h0000);
        use_rnd   = !hit && !any_free && (r_mode == sactc_pkg::MODE_RANDOM);
        if (hit) begin
            way = hit_way;
        end else if (any_free) begin
            way = free_way;
        end else begin
            unique case (r_mode)
                sactc_pkg::MODE_FIFO:   way = old_fr_way;
                sactc_pkg::MODE_RANDOM: way = f_lfsr_way(lfsr_step);
                default:                way = old_rr_way;
            endcase
        end
        was_valid = vbits[way];
        wb        = !hit && was_valid && dbits[way];
        victim    = wb ? (32'((64'(row_tag[way]) << (OB + IB)) | (64'(s1_set) << OB)) & AMASK)
                       : 32'd0;
        fill      = hit ? 32'd0 : (addr_m & ~LMASK);
    end

    // rank, tag and line state update
    always_comb begin
        n_tag   = row_tag;
        n_vbits = vbits;
        n_dbits = dbits;
        for (int v = 0; v < WAYS; v++) begin
            n_rr[v] = row_rr[v];
            n_fr[v] = row_fr[v];
            if (WW'(v) == way) begin
                n_rr[v] = '0;
                if (!hit) n_fr[v] = '0;
            end else if (vbits[v]) begin
                if (!was_valid || (row_rr[v] < row_rr[way])) begin
                    n_rr[v] = WW'(row_rr[v] + WW'(1));
                end
                if (!hit && (!was_valid || (row_fr[v] < row_fr[way]))) begin
                    n_fr[v] = WW'(row_fr[v] + WW'(1));
                end
            end
        end
        if (hit) begin
            n_dbits[way] = dbits[way] | r_s1_func;
        end else begin
            n_tag[way]   = s1_tag;
            n_vbits[way] = 1'b1;
            n_dbits[way] = r_s1_func;
        end
        wr_row   = {n_tag, n_rr, n_fr, n_dbits};
        n_hits   = (hit && (r_hits != 32'hFFFF_FFFF)) ? r_hits + 32'd1 : r_hits;
        n_misses = (!hit && (r_misses != 32'hFFFF_FFFF)) ? r_misses + 32'd1 : r_misses;
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func <= i_func;
            r_s1_addr <= i_address;
            r_fwd_hit <= s1_adv && (s1_set == in_set);
        end
        if (s1_adv) begin
            r_fwd_row <= wr_row;
        end
    end

    // line valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (s1_adv) begin
            r_valid[s1_set] <= n_vbits;
        end
    end

    // configuration, lfsr and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sactc_pkg::MODE_LRU;
            r_lfsr   <= sactc_pkg::SEED_RESET;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == sactc_pkg::REG_REPLACEMENT_MODE)) begin
                r_mode <= i_cfg_data[1:0];
            end
            if (i_cfg_valid && (i_cfg_index == sactc_pkg::REG_RANDOM_SEED)) begin
                r_lfsr <= i_cfg_data;
            end else if (s1_adv && use_rnd) begin
                r_lfsr <= lfsr_step;
            end
            if (s1_adv) begin
                r_hits   <= n_hits;
                r_misses <= n_misses;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_hit    <= hit;
            r_out_way    <= sactc_pkg::WAY_W'(way);
            r_out_wb     <= wb;
            r_out_victim <= victim;
            r_out_fill   <= fill;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_hit            = r_out_hit;
    assign o_way            = r_out_way;
    assign o_writeback      = r_out_wb;
    assign o_victim_address = r_out_victim;
    assign o_fill_address   = r_out_fill;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cache tag controller. Access words are queued
// per phase and driven in random bursts while the result side stalls on a
// fixed pattern. A directory model in the bench predicts hit, way,
// write-back, victim, fill and the counters. Phases run lru, fifo, random
// and the undefined mode under several seeds, including zero.
// ----------------------------------------------------------------------------
module testbench;

    // directory geometry of the default build
    localparam int OFFSET_W = 4;
    localparam int SET_W    = 6;
    localparam int TAG_W    = sactc_pkg::ADDR_W - OFFSET_W - SET_W;
    localparam int NUM_SETS = 1 << SET_W;
    localparam int NUM_WAYS = 4;

    // codes the package does not name
    localparam logic [sactc_pkg::CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
    localparam logic [sactc_pkg::CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;
    localparam sactc_pkg::t_mode MODE_UNDEFINED = 2'd3;
    localparam logic  FUNC_READ      = 1'b0;
    localparam logic  FUNC_WRITE     = 1'b1;

    localparam int LIMIT_TIME = 2_000_000;

    typedef struct packed {
        logic                         func;
        logic [sactc_pkg::ADDR_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic                          hit;
        logic [sactc_pkg::WAY_W-1:0]   way;
        logic                          writeback;
        logic [sactc_pkg::ADDR_W-1:0]  victim_address;
        logic [sactc_pkg::ADDR_W-1:0]  fill_address;
        logic [sactc_pkg::COUNT_W-1:0] hit_total;
        logic [sactc_pkg::COUNT_W-1:0] miss_total;
    } t_lookup;

    typedef logic [NUM_WAYS-1:0][1:0] t_rank;

    // block ports, all inputs known from time zero
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [sactc_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [sactc_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic                              i_func      = 1'b0;
    logic [sactc_pkg::ADDR_W-1:0]      i_address   = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic                              o_hit;
    logic [sactc_pkg::WAY_W-1:0]       o_way;
    logic                              o_writeback;
    logic [sactc_pkg::ADDR_W-1:0]      o_victim_address;
    logic [sactc_pkg::ADDR_W-1:0]      o_fill_address;
    logic [sactc_pkg::COUNT_W-1:0]     o_hit_total;
    logic [sactc_pkg::COUNT_W-1:0]     o_miss_total;

    // directory model
    logic [NUM_WAYS-1:0]           way_valid [NUM_SETS];
    logic [NUM_WAYS-1:0]           way_dirty [NUM_SETS];
    logic [TAG_W-1:0]              way_tag   [NUM_SETS][NUM_WAYS];
    t_rank                         use_age   [NUM_SETS];
    t_rank                         fill_age  [NUM_SETS];
    sactc_pkg::t_mode              cur_mode;
    logic [sactc_pkg::LFSR_W-1:0]  lfsr_state;
    logic [sactc_pkg::COUNT_W-1:0] hits_seen;
    logic [sactc_pkg::COUNT_W-1:0] misses_seen;

    // queues and bookkeeping
    t_access access_q [$];
    t_lookup awaited_lookups [$];
    int      words_queued  = 0;
    int      words_checked = 0;
    int      mismatches    = 0;
    int      phases_run    = 0;
    int      burst_left    = 0;
    int      gap_left      = 0;
    logic    sender_idles  = 1'b1;
    logic [15:0] ready_mask  = '1;
    logic [3:0]  stall_phase = '0;

    set_assoc_cache_tag_controller_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_address        (i_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hit            (o_hit),
        .o_way            (o_way),
        .o_writeback      (o_writeback),
        .o_victim_address (o_victim_address),
        .o_fill_address   (o_fill_address),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // make way w the youngest, aging the live ways that were younger (all live ways when w was not live)
    function automatic t_rank promote(t_rank r, logic [NUM_WAYS-1:0] live, int w,
                                      logic was_live);
        t_rank n;
        int    v;
        n = r;
        for (v = 0; v < NUM_WAYS; v++)
            if (v != w && live[v] && (!was_live || r[v] < r[w]))
                n[v] = r[v] + 2'd1;
        n[w] = 2'd0;
        return n;
    endfunction

    // highest rank, lowest way on a tie
    function automatic int oldest_way(t_rank r);
        int best;
        int v;
        best = 0;
        for (v = 1; v < NUM_WAYS; v++)
            if (r[v] > r[best])
                best = v;
        return best;
    endfunction

    // look one access up in the model directory and update it
    function automatic t_lookup predict_lookup(logic func,
                                               logic [sactc_pkg::ADDR_W-1:0] addr);
        t_lookup          res;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic             was_live;
        int               w;
        res     = '0;
        set_idx = addr[OFFSET_W +: SET_W];
        tag     = addr[sactc_pkg::ADDR_W-1 -: TAG_W];
        // downward scan so the lowest matching way wins
        for (w = NUM_WAYS - 1; w >= 0; w--)
            if (way_valid[set_idx][w] && way_tag[set_idx][w] == tag) begin
                res.hit = 1'b1;
                res.way = sactc_pkg::WAY_W'(w);
            end
        if (res.hit) begin
            if (hits_seen != '1)
                hits_seen = hits_seen + sactc_pkg::COUNT_W'(1);
            use_age[set_idx] = promote(use_age[set_idx], way_valid[set_idx],
                                       int'(res.way), 1'b1);
            if (func == FUNC_WRITE)
                way_dirty[set_idx][res.way] = 1'b1;
        end else begin
            if (misses_seen != '1)
                misses_seen = misses_seen + sactc_pkg::COUNT_W'(1);
            // lowest free way first, else the replacement choice
            if (way_valid[set_idx] != '1) begin
                for (w = NUM_WAYS - 1; w >= 0; w--)
                    if (!way_valid[set_idx][w])
                        res.way = sactc_pkg::WAY_W'(w);
            end else if (cur_mode == sactc_pkg::MODE_FIFO) begin
                res.way = sactc_pkg::WAY_W'(oldest_way(fill_age[set_idx]));
            end else if (cur_mode == sactc_pkg::MODE_RANDOM) begin
                lfsr_state = {1'b0, lfsr_state[sactc_pkg::LFSR_W-1:1]}
                             ^ (lfsr_state[0] ? sactc_pkg::LFSR_TAPS : '0);
                res.way = lfsr_state[sactc_pkg::WAY_W-1:0];
            end else begin
                res.way = sactc_pkg::WAY_W'(oldest_way(use_age[set_idx]));
            end
            was_live = way_valid[set_idx][res.way];
            if (was_live && way_dirty[set_idx][res.way]) begin
                res.writeback      = 1'b1;
                res.victim_address = {way_tag[set_idx][res.way], set_idx, {OFFSET_W{1'b0}}};
            end
            res.fill_address = {addr[sactc_pkg::ADDR_W-1:OFFSET_W], {OFFSET_W{1'b0}}};
            use_age[set_idx]  = promote(use_age[set_idx], way_valid[set_idx],
                                        int'(res.way), was_live);
            fill_age[set_idx] = promote(fill_age[set_idx], way_valid[set_idx],
                                        int'(res.way), was_live);
            way_valid[set_idx][res.way] = 1'b1;
            way_tag[set_idx][res.way]   = tag;
            way_dirty[set_idx][res.way] = func;
        end
        res.hit_total  = hits_seen;
        res.miss_total = misses_seen;
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want,
                                          logic [31:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("mismatch on word %0d, %s: expected %h, got %h",
                         words_checked, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [sactc_pkg::ADDR_W-1:0] line_address(
            logic [TAG_W-1:0] tag, logic [SET_W-1:0] set_idx,
            logic [OFFSET_W-1:0] offset);
        return {tag, set_idx, offset};
    endfunction

    // model update on accepted config and access words
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == sactc_pkg::REG_REPLACEMENT_MODE)
                cur_mode = i_cfg_data[1:0];
            else if (i_cfg_index == sactc_pkg::REG_RANDOM_SEED)
                lfsr_state = i_cfg_data;
        end
        if (i_rst_n && i_in_valid && o_in_ready)
            awaited_lookups.push_back(predict_lookup(i_func, i_address));
    end

    // access driver: bursts of words with random gaps when the sender idles
    always @(posedge i_clk) begin : access_driver
        t_access nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (access_q.size() != 0) begin
                nxt = access_q.pop_front();
                i_in_valid <= 1'b1;
                i_func     <= nxt.func;
                i_address  <= nxt.address;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= sender_idles ? $urandom_range(0, 6) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor with a rotating stall pattern
    always @(posedge i_clk) begin : result_monitor
        t_lookup want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ready_mask[stall_phase];
            stall_phase <= stall_phase + 4'd1;
            if (o_out_valid && i_out_ready) begin
                if (awaited_lookups.size() == 0) begin
                    if (mismatches < 10)
                        $display("result word with nothing awaited, fill %h", o_fill_address);
                    mismatches++;
                end else begin
                    want = awaited_lookups.pop_front();
                    compare_field("hit", 32'(want.hit), 32'(o_hit));
                    compare_field("way", 32'(want.way), 32'(o_way));
                    compare_field("writeback", 32'(want.writeback), 32'(o_writeback));
                    compare_field("victim_address", want.victim_address, o_victim_address);
                    compare_field("fill_address", want.fill_address, o_fill_address);
                    compare_field("hit_total", want.hit_total, o_hit_total);
                    compare_field("miss_total", want.miss_total, o_miss_total);
                end
                words_checked++;
            end
        end
    end

    task automatic queue_access(logic func, logic [sactc_pkg::ADDR_W-1:0] addr);
        t_access a;
        a.func    = func;
        a.address = addr;
        access_q.push_back(a);
        words_queued++;
    endtask

    // config write, only issued while the block is idle
    task automatic write_reg(logic [sactc_pkg::CFG_INDEX_W-1:0] idx,
                             logic [sactc_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mode write with random upper data bits
    task automatic write_mode(sactc_pkg::t_mode mode);
        logic [31:0] rnd;
        rnd = $urandom;
        write_reg(sactc_pkg::REG_REPLACEMENT_MODE,
                  {rnd[sactc_pkg::CFG_DATA_W-1:2], mode});
    endtask

    task automatic wait_idle;
        while (words_checked != words_queued)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // random accesses crowding a few sets with a few tags, plus some noise
    task automatic run_phase(int n, logic idles, logic [15:0] mask);
        logic [SET_W-1:0] set_pool [3];
        logic [TAG_W-1:0] tag_pool [6];
        logic [31:0]      rnd;
        int               i;
        sender_idles = idles;
        ready_mask   = mask;
        set_pool[0] = '0;
        set_pool[1] = '1;
        set_pool[2] = SET_W'($urandom);
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (i = 2; i < 6; i++)
            tag_pool[i] = TAG_W'($urandom);
        for (i = 0; i < n; i++) begin
            rnd = $urandom;
            if ($urandom_range(0, 99) < 85)
                queue_access(1'($urandom_range(0, 1)),
                             line_address(tag_pool[$urandom_range(0, 5)],
                                          set_pool[$urandom_range(0, 2)],
                                          rnd[OFFSET_W-1:0]));
            else
                queue_access(1'($urandom_range(0, 1)), $urandom);
        end
        wait_idle();
        phases_run++;
    endtask

    // run timeout
    initial begin
        #LIMIT_TIME;
        $display("timeout with %0d of %0d words checked", words_checked, words_queued);
        $display("RESULT: ERROR");
        $finish;
    end

    // phase sequence
    initial begin : sequencer
        int s;
        for (s = 0; s < NUM_SETS; s++) begin
            way_valid[s] = '0;
            way_dirty[s] = '0;
            use_age[s]   = '0;
            fill_age[s]  = '0;
        end
        cur_mode    = sactc_pkg::MODE_LRU;
        lfsr_state  = sactc_pkg::SEED_RESET;
        hits_seen   = '0;
        misses_seen = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under the reset settings (lru)
        queue_access(FUNC_READ,  32'h0000_0000);
        queue_access(FUNC_WRITE, 32'hFFFF_FFFF);
        queue_access(FUNC_READ,  32'h0000_000C);
        queue_access(FUNC_WRITE, line_address(22'h000001, 6'd0, 4'h0));
        queue_access(FUNC_WRITE, line_address(22'h2AAAAA, 6'd0, 4'h5));
        queue_access(FUNC_READ,  line_address(22'h155555, 6'd0, 4'hF));
        // set 0 full; after the hit on tag 0 the oldest use is the dirty tag 1 line
        queue_access(FUNC_READ,  32'h0000_0000);
        queue_access(FUNC_READ,  line_address(22'h200000, 6'd0, 4'h0));
        queue_access(FUNC_WRITE, line_address(22'h2AAAAA, 6'd0, 4'h3));
        queue_access(FUNC_READ,  line_address(22'h155555, 6'd0, 4'h0));
        // clean victims next
        queue_access(FUNC_WRITE, line_address(22'h0F0F0F, 6'd0, 4'h0));
        queue_access(FUNC_WRITE, 32'hFFFF_FFF0);
        queue_access(FUNC_READ,  line_address(22'h3FFFFF, 6'd0, 4'h0));
        queue_access(FUNC_READ,  32'h0000_0010);
        // a write hit on the all-ones tag line in set 63, then a dirty and a clean victim in set 0
        queue_access(FUNC_WRITE, line_address(22'h3FFFFF, 6'd63, 4'h8));
        queue_access(FUNC_READ,  line_address(22'h000002, 6'd0, 4'h0));
        queue_access(FUNC_READ,  line_address(22'h000003, 6'd0, 4'h0));
        run_phase(100, 1'b0, 16'hFFFF);

        // fifo
        write_mode(sactc_pkg::MODE_FIFO);
        run_phase(130, 1'b1, 16'hA5C3);

        // random on the reset seed, then on the all-ones seed
        write_mode(sactc_pkg::MODE_RANDOM);
        run_phase(130, 1'b1, 16'hFFFF);
        write_reg(sactc_pkg::REG_RANDOM_SEED, 16'hFFFF);
        run_phase(130, 1'b1, 16'h0101);

        // undefined mode behaves as lru; spare indexes change nothing
        write_mode(MODE_UNDEFINED);
        write_reg(REG_SPARE_LOW, sactc_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HIGH, sactc_pkg::CFG_DATA_W'($urandom));
        run_phase(130, 1'b1, 16'h7BDE);

        // random on the smallest seed, then a stuck zero lfsr
        write_mode(sactc_pkg::MODE_RANDOM);
        write_reg(sactc_pkg::REG_RANDOM_SEED, 16'h0001);
        run_phase(130, 1'b0, 16'hC3F0);
        write_reg(sactc_pkg::REG_RANDOM_SEED, 16'h0000);
        run_phase(100, 1'b1, 16'hFFFF);

        // back to lru on a random seed
        write_reg(sactc_pkg::REG_RANDOM_SEED,
                  sactc_pkg::CFG_DATA_W'($urandom_range(1, 65535)));
        write_mode(sactc_pkg::MODE_LRU);
        run_phase(100, 1'b1, 16'($urandom) | 16'h0001);

        mismatches += awaited_lookups.size();
        $display("checked %0d lookup words over %0d phases: %0d hits, %0d misses",
                 words_checked, phases_run, hits_seen, misses_seen);
        $display("modes lru, fifo, random and undefined; seeds reset, max, min and zero");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: set_assoc_cache_tag_controller_unit.f
sv/sactc_pkg.sv
sv/sactc_ram.sv
sv/set_assoc_cache_tag_controller_unit.sv
test/testbench.sv
